// ===== src/mbpu_pkg.sv =====
// ----------------------------------------------------------------------------
// MSB-first bit packer package
// Request codes, transfer payload types and the chunk unit status type.
// ----------------------------------------------------------------------------
package mbpu_pkg;

  localparam int unsigned ByteBits = 8;
  localparam int unsigned FreeW    = 4;

  typedef enum logic [1:0] {
    REQ_PUT_BITS = 2'd0,
    REQ_PUT_RUN  = 2'd1,
    REQ_FLUSH    = 2'd2,
    REQ_NONE     = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] value;
    logic [5:0]  num_bits;
    logic [7:0]  zero_run;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } out_t;

  typedef struct packed {
    logic [ByteBits-1:0] part;
    logic [FreeW-1:0]    free;
    logic                full;
    logic                last;
    logic                done;
  } chunk_res_t;

endpackage

// ===== src/mbpu_chunk.sv =====
// ----------------------------------------------------------------------------
// Chunk insertion unit
// Moves the next up to eight source bits into the partial byte in one step.
// ----------------------------------------------------------------------------
module mbpu_chunk #(
  parameter int unsigned SrcW = 32,
  parameter int unsigned CntW = 9
) (
  input  logic [SrcW-1:0]              src_i,
  input  logic [CntW-1:0]              cnt_i,
  input  logic [mbpu_pkg::FreeW-1:0]   free_i,
  input  logic [mbpu_pkg::ByteBits-1:0] part_i,
  output logic [CntW-1:0]              cnt_o,
  output mbpu_pkg::chunk_res_t         res_o
);

  logic [mbpu_pkg::FreeW-1:0]    take;
  logic [CntW-1:0]               rest;
  logic [SrcW-1:0]               shifted;
  logic [mbpu_pkg::ByteBits-1:0] mask;
  logic [mbpu_pkg::ByteBits-1:0] bits;
  logic [mbpu_pkg::FreeW-1:0]    new_free;

  always_comb begin
    if (cnt_i < CntW'(free_i)) begin
      take = cnt_i[mbpu_pkg::FreeW-1:0];
    end else begin
      take = free_i;
    end
    rest     = cnt_i - CntW'(take);
    shifted  = src_i >> rest;
    mask     = 8'hFF >> (4'd8 - take);
    bits     = shifted[mbpu_pkg::ByteBits-1:0] & mask;
    new_free = free_i - take;
    res_o.part = part_i | (bits << new_free);
    res_o.free = new_free;
    res_o.full = (new_free == '0);
    res_o.last = (rest < CntW'(8));
    res_o.done = (rest == '0);
    cnt_o      = rest;
  end

endmodule

// ===== src/msb_first_bit_packer_unary.sv =====
// ----------------------------------------------------------------------------
// MSB-first bit packer with unary code
// Packs put-bits, zero-run and flush requests into a byte stream.
// ----------------------------------------------------------------------------
// Requests arrive on the in channel (in_valid_i, in_stall_o, in_i) and
// completed bytes leave on the out channel (out_valid_o, out_stall_i,
// out_o); a transfer happens when valid is high and stall is low.
// A put-bits request appends the low num_bits bits of value, highest first.
// A zero-run request appends zero_run zeros and then a one. A flush pads a
// partial byte with zeros. The final byte of each request has last_byte set.
// After a request transfer the sequencer runs one step per cycle; each step
// moves up to the number of free bits in the partial byte (at most eight)
// through the shared chunk unit. A request of n bits takes about n/8 + 1
// steps, e.g. up to five for 32 bits and up to 33 for a long run, and the
// next request is taken in the cycle after the final step; a completed byte
// can be taken by the receiver in the cycle after the step that completes it.
// The block stalls its input until the request is finished, and a step that
// completes a byte waits while the output register holds an untaken byte.
// A receiver stall therefore holds the sequencer without losing any bits.
// Reset empties the partial byte and the output register.
// ----------------------------------------------------------------------------
module msb_first_bit_packer_unary #(
  parameter int unsigned MAX_FIELD_BITS = 32,
  parameter int unsigned MAX_ZERO_RUN   = 255
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  mbpu_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output mbpu_pkg::out_t out_o
);

  localparam int unsigned SrcW   = (MAX_FIELD_BITS > 32) ? MAX_FIELD_BITS : 32;
  localparam int unsigned MaxCnt = (MAX_FIELD_BITS > MAX_ZERO_RUN + 1) ?
                                   MAX_FIELD_BITS : MAX_ZERO_RUN + 1;
  localparam int unsigned CntW   = $clog2(MaxCnt + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BITS,
    ST_FLUSH
  } state_e;

  state_e                        state_q;
  logic [SrcW-1:0]               src_q;
  logic [CntW-1:0]               cnt_q;
  logic [mbpu_pkg::ByteBits-1:0] part_q;
  logic [mbpu_pkg::FreeW-1:0]    free_q;
  logic                          out_valid_q;
  mbpu_pkg::out_t                out_q;

  logic [CntW-1:0]      cnt_next;
  mbpu_pkg::chunk_res_t res;
  logic                 accept;
  logic                 out_free;
  logic [CntW-1:0]      put_cnt;
  logic [CntW-1:0]      run_cnt;

  mbpu_chunk #(
    .SrcW (SrcW),
    .CntW (CntW)
  ) u_chunk (
    .src_i  (src_q),
    .cnt_i  (cnt_q),
    .free_i (free_q),
    .part_i (part_q),
    .cnt_o  (cnt_next),
    .res_o  (res)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    if (CntW'(in_i.num_bits) > CntW'(MAX_FIELD_BITS)) begin
      put_cnt = CntW'(MAX_FIELD_BITS);
    end else begin
      put_cnt = CntW'(in_i.num_bits);
    end
    if (CntW'(in_i.zero_run) > CntW'(MAX_ZERO_RUN)) begin
      run_cnt = CntW'(MAX_ZERO_RUN + 1);
    end else begin
      run_cnt = CntW'(in_i.zero_run) + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      part_q      <= '0;
      free_q      <= mbpu_pkg::FreeW'(mbpu_pkg::ByteBits);
      out_valid_q <= 1'b0;
      src_q       <= '0;
      cnt_q       <= '0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            case (mbpu_pkg::req_type_e'(in_i.req_type))
              mbpu_pkg::REQ_PUT_BITS: begin
                src_q <= SrcW'(in_i.value);
                cnt_q <= put_cnt;
                if (put_cnt != '0) begin
                  state_q <= ST_BITS;
                end
              end
              mbpu_pkg::REQ_PUT_RUN: begin
                src_q   <= SrcW'(1);
                cnt_q   <= run_cnt;
                state_q <= ST_BITS;
              end
              mbpu_pkg::REQ_FLUSH: begin
                if (free_q != mbpu_pkg::FreeW'(mbpu_pkg::ByteBits)) begin
                  state_q <= ST_FLUSH;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_BITS: begin
          if (out_free || !res.full) begin
            cnt_q <= cnt_next;
            if (res.full) begin
              out_q.out_byte  <= res.part;
              out_q.last_byte <= res.last;
              out_valid_q     <= 1'b1;
              part_q          <= '0;
              free_q          <= mbpu_pkg::FreeW'(mbpu_pkg::ByteBits);
            end else begin
              part_q <= res.part;
              free_q <= res.free;
            end
            if (res.done) begin
              state_q <= ST_IDLE;
            end
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_q.out_byte  <= part_q;
            out_q.last_byte <= 1'b1;
            out_valid_q     <= 1'b1;
            part_q          <= '0;
            free_q          <= mbpu_pkg::FreeW'(mbpu_pkg::ByteBits);
            state_q         <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (free_q != '0) && (free_q <= mbpu_pkg::FreeW'(mbpu_pkg::ByteBits)))
    else $error("free bit count out of range");

  a_more_after_inner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_o.last_byte) |-> (state_q == ST_BITS))
    else $error("non-final byte left with no request in progress");

  a_put_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_i.req_type == mbpu_pkg::REQ_PUT_RUN)) |=> (state_q == ST_BITS))
    else $error("zero-run request did not start the sequencer");

  a_flush_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |-> (free_q != mbpu_pkg::FreeW'(mbpu_pkg::ByteBits)))
    else $error("flush entered on a byte boundary");

endmodule
